// File: sv/zero_padded_moving_average_defines.svh
// ----------------------------------------------------------------------------
// Moving average assertion macros
// Clocked assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ZERO_PADDED_MOVING_AVERAGE_DEFINES_SVH
`define ZERO_PADDED_MOVING_AVERAGE_DEFINES_SVH

`ifndef SYNTH
`define ZPMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ZPMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ZPMA_ASSERT(lbl, prop, msg)
`define ZPMA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/zpma_pkg.sv
// ----------------------------------------------------------------------------
// Moving average package
// Sizes, controller states and the history memory request bundle.
// ----------------------------------------------------------------------------
package zpma_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int PTR_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W        = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W        = SAMPLE_WIDTH + $clog2(MAX_WINDOW) + 1 - 1;
  localparam int CNT_W        = $clog2(SUM_W + 1);
  localparam int WIN_RESET    = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_DIV,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic                           rd_en;
    logic [PTR_W-1:0]               rd_addr;
    logic                           wr_en;
    logic [PTR_W-1:0]               wr_addr;
    logic signed [SAMPLE_WIDTH-1:0] wr_data;
  } ring_req_t;

endpackage

// File: sv/zpma_ring.sv
// ----------------------------------------------------------------------------
// Moving average history ring
// Single-port-write, registered-read sample memory.
// ----------------------------------------------------------------------------
module zpma_ring (
  input  logic                                      clk_i,
  input  zpma_pkg::ring_req_t                       req_i,
  output logic signed [zpma_pkg::SAMPLE_WIDTH-1:0]  rd_data_o
);

  logic signed [zpma_pkg::SAMPLE_WIDTH-1:0] mem [zpma_pkg::MAX_WINDOW];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem[req_i.rd_addr];
    end
  end

endmodule

// File: sv/zpma_div.sv
// ----------------------------------------------------------------------------
// Moving average divider
// Signed sum by unsigned window, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`include "zero_padded_moving_average_defines.svh"

module zpma_div (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic signed [zpma_pkg::SUM_W-1:0]         dividend_i,
  input  logic [zpma_pkg::WIN_W-1:0]                divisor_i,
  output logic                                      done_o,
  output logic signed [zpma_pkg::SAMPLE_WIDTH-1:0]  quotient_o
);

  localparam int SW = zpma_pkg::SUM_W;
  localparam int WW = zpma_pkg::WIN_W;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [zpma_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [SW-1:0]   quo_q, quo_d;
  logic [WW-1:0]   rem_q, rem_d;
  logic [WW-1:0]   div_q, div_d;
  logic            neg_q, neg_d;

  logic [WW:0]     trial;
  logic [WW:0]     diff;
  logic            ge;
  logic [SW-1:0]   mag;
  logic [SW-1:0]   q_full;

  always_comb begin
    trial = {rem_q, quo_q[SW-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
    mag   = dividend_i[SW-1] ? (SW'(0) - SW'(dividend_i)) : SW'(dividend_i);

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    neg_d  = neg_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = zpma_pkg::CNT_W'(SW);
      quo_d  = mag;
      rem_d  = '0;
      div_d  = divisor_i;
      neg_d  = dividend_i[SW-1];
    end else if (busy_q) begin
      quo_d = {quo_q[SW-2:0], ge};
      rem_d = ge ? diff[WW-1:0] : trial[WW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == zpma_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end

    q_full     = neg_q ? (SW'(0) - quo_q) : quo_q;
    quotient_o = q_full[zpma_pkg::SAMPLE_WIDTH-1:0];
    done_o     = done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  `ZPMA_ASSERT(a_start_when_free, start_i |-> !busy_q, "divider restarted while busy")
  `ZPMA_ASSERT(a_done_ends_busy, done_o |-> !busy_q && $past(busy_q), "done without a run")

endmodule

// File: sv/zero_padded_moving_average.sv
// ----------------------------------------------------------------------------
// Zero-padded moving average
// Boxcar mean of signed Q8.8 samples over a programmable window.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_stall_o with sample_i and start_req_i. A beat
// with start_req_i set opens a new vector; earlier samples count as zero.
// Output channel: out_valid_o/out_stall_i with average_o, one beat per input
// beat, the sum of the last window_length samples divided by window_length,
// truncated toward zero.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_data_i writes the window
// length (0 acts as 1, above 64 acts as 64) and clears the history. Ready
// only while no beat is in flight and no input beat is offered.
// Path: the history memory read, the sum update, the bit-serial divider
// and the output register, in that order. One beat is in flight at a
// time, so a new beat is taken only once the previous result has been
// loaded into the output register.
// A result waiting on a stalled receiver does not block the next beat;
// that beat holds at the divider until the output register frees.
// Reset clears sum, count and pointer and sets the window to 4; the memory
// needs no clearing since an entry's read value is only used once written.
// ----------------------------------------------------------------------------
`include "zero_padded_moving_average_defines.svh"

module zero_padded_moving_average (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic signed [zpma_pkg::SAMPLE_WIDTH-1:0]  sample_i,
  input  logic                                      start_req_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic signed [zpma_pkg::SAMPLE_WIDTH-1:0]  average_o,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [zpma_pkg::WIN_W-1:0]                cfg_data_i
);

  localparam int SW = zpma_pkg::SUM_W;
  localparam int WW = zpma_pkg::WIN_W;
  localparam int PW = zpma_pkg::PTR_W;
  localparam int DW = zpma_pkg::SAMPLE_WIDTH;

  zpma_pkg::state_e state_q, state_d;

  logic [WW-1:0]        window_q, window_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic [PW-1:0]        ptr_q, ptr_d;
  logic [WW-1:0]        seen_q, seen_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [DW-1:0] average_q, average_d;
  logic signed [DW-1:0] sample_q, sample_d;
  logic                 sub_q, sub_d;

  logic [WW-1:0]        win_eff;
  logic                 in_acc;
  logic                 cfg_acc;
  logic                 out_free;
  logic                 load_out;
  logic signed [SW-1:0] base_sum;
  logic [PW-1:0]        base_ptr;
  logic [WW-1:0]        base_seen;
  logic [WW-1:0]        oldest_ext;
  logic signed [SW-1:0] old_ext;
  logic signed [SW-1:0] new_ext;

  zpma_pkg::ring_req_t        ring_req;
  logic signed [DW-1:0]       ring_rdata;
  logic                       div_start;
  logic                       div_done;
  logic signed [DW-1:0]       div_quot;

  zpma_ring u_ring (
    .clk_i     (clk_i),
    .req_i     (ring_req),
    .rd_data_o (ring_rdata)
  );

  zpma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (win_eff),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    if (window_q == '0) begin
      win_eff = WW'(1);
    end else if (window_q > WW'(zpma_pkg::MAX_WINDOW)) begin
      win_eff = WW'(zpma_pkg::MAX_WINDOW);
    end else begin
      win_eff = window_q;
    end

    in_stall_o  = (state_q != zpma_pkg::ST_IDLE);
    cfg_ready_o = (state_q == zpma_pkg::ST_IDLE) && !in_valid_i;
    in_acc      = in_valid_i && !in_stall_o;
    cfg_acc     = cfg_valid_i && cfg_ready_o;
    out_free    = !out_valid_q || !out_stall_i;

    base_sum   = start_req_i ? '0 : sum_q;
    base_ptr   = start_req_i ? '0 : ptr_q;
    base_seen  = start_req_i ? '0 : seen_q;
    oldest_ext = WW'(base_ptr) - win_eff;

    old_ext = {{(SW-DW){ring_rdata[DW-1]}}, ring_rdata};
    new_ext = {{(SW-DW){sample_q[DW-1]}}, sample_q};

    state_d     = state_q;
    window_d    = window_q;
    sum_d       = sum_q;
    ptr_d       = ptr_q;
    seen_d      = seen_q;
    sample_d    = sample_q;
    sub_d       = sub_q;
    div_start   = 1'b0;
    load_out    = 1'b0;

    ring_req.rd_en   = 1'b0;
    ring_req.rd_addr = oldest_ext[PW-1:0];
    ring_req.wr_en   = 1'b0;
    ring_req.wr_addr = ptr_q;
    ring_req.wr_data = sample_q;

    case (state_q)
      zpma_pkg::ST_IDLE: begin
        if (cfg_acc) begin
          window_d = cfg_data_i;
          sum_d    = '0;
          ptr_d    = '0;
          seen_d   = '0;
        end else if (in_acc) begin
          sample_d       = sample_i;
          sub_d          = (base_seen >= win_eff);
          sum_d          = base_sum;
          ptr_d          = base_ptr;
          seen_d         = (base_seen >= win_eff) ? base_seen : base_seen + 1'b1;
          ring_req.rd_en = 1'b1;
          state_d        = zpma_pkg::ST_RD;
        end
      end
      zpma_pkg::ST_RD: begin
        sum_d          = sum_q - (sub_q ? old_ext : '0) + new_ext;
        ring_req.wr_en = 1'b1;
        ptr_d          = ptr_q + 1'b1;
        div_start      = 1'b1;
        state_d        = zpma_pkg::ST_DIV;
      end
      zpma_pkg::ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = zpma_pkg::ST_IDLE;
          end else begin
            state_d = zpma_pkg::ST_HOLD;
          end
        end
      end
      zpma_pkg::ST_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = zpma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = zpma_pkg::ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    average_d   = average_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      average_d   = div_quot;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    out_valid_o = out_valid_q;
    average_o   = average_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= zpma_pkg::ST_IDLE;
      window_q    <= WW'(zpma_pkg::WIN_RESET);
      sum_q       <= '0;
      ptr_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      sum_q       <= sum_d;
      ptr_q       <= ptr_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    average_q <= average_d;
    sample_q  <= sample_d;
    sub_q     <= sub_d;
  end

  `ZPMA_ASSERT(a_done_in_div, div_done |-> (state_q == zpma_pkg::ST_DIV), "stray divider done")
  `ZPMA_ASSERT(a_seen_bounded, seen_q <= win_eff, "sample count above window")
  `ZPMA_ASSERT(a_out_from_div, $rose(out_valid_o) |-> $past(state_q == zpma_pkg::ST_DIV ||
               state_q == zpma_pkg::ST_HOLD), "result without division")
  `ZPMA_ASSERT_ALWAYS(a_cfg_idle, cfg_ready_o |-> !in_stall_o, "config taken while busy")

endmodule
